@@ design/sskc_pkg.sv @@
// ---------------------------------------------------------------------------
// sskc_pkg
// Shared types, constants and constant tables for the stereo compressor.
// ---------------------------------------------------------------------------
package sskc_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEADROOM  = 3'd0,
        REG_THRESHOLD = 3'd1,
        REG_KNEE      = 3'd2,
        REG_RATIO     = 3'd3,
        REG_ATTACK    = 3'd4,
        REG_RELEASE   = 3'd5
    } cfg_reg_t;

    localparam logic [16:0] HEADROOM_RST  = 17'd65536;
    localparam logic [14:0] THRESHOLD_RST = 15'h7A00;     // -1536
    localparam logic [12:0] KNEE_RST      = 13'd1536;
    localparam logic [14:0] RATIO_RST     = 15'd1024;
    localparam logic [23:0] ATTACK_RST    = 24'd16742315;
    localparam logic [23:0] RELEASE_RST   = 24'd16773721;

    localparam logic [16:0] UNITY_Q16       = 17'd65536;
    localparam logic [14:0] RATIO_MIN       = 15'd256;
    localparam logic [31:0] DB_PER_LOG2_Q16 = 32'd394566;
    localparam logic [31:0] LOG2_PER_DB_Q16 = 32'd2786635;
    localparam logic signed [16:0] MIN_DB_Q8 = -17'sd30720;
    localparam logic [23:0] FULL_SCALE      = 24'd8388608;
    localparam logic [30:0] PEAK_MAX        = 31'h7FFF_FFFF;

    localparam int unsigned NUM_W  = 43;   // divider numerator width (hard and soft knee)
    localparam int unsigned ROOT_N = 16;

    typedef logic [31:0] root_tab_t [ROOT_N];

    typedef enum logic [20:0] {
        ST_IDLE  = 21'h000001,
        ST_SCL   = 21'h000002,
        ST_SCR   = 21'h000004,
        ST_PEAK  = 21'h000008,
        ST_ENV1  = 21'h000010,
        ST_ENV2  = 21'h000020,
        ST_NORM  = 21'h000040,
        ST_SQR   = 21'h000080,
        ST_DB    = 21'h000100,
        ST_OVER  = 21'h000200,
        ST_SOFT1 = 21'h000400,
        ST_SOFT2 = 21'h000800,
        ST_SOFT3 = 21'h001000,
        ST_DIV   = 21'h002000,
        ST_GAIN  = 21'h004000,
        ST_LIN   = 21'h008000,
        ST_LINF  = 21'h010000,
        ST_LINS  = 21'h020000,
        ST_APPL  = 21'h040000,
        ST_APPR  = 21'h080000,
        ST_DONE  = 21'h100000
    } state_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] n);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bitv;
        rem  = n;
        root = '0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // 2^(2^-(j+1)) in Q30, each entry the square root of the one before
    function automatic root_tab_t build_roots();
        root_tab_t   tab;
        logic [63:0] c;
        c = isqrt64(64'd1 << 61);
        for (int j = 0; j < ROOT_N; j++) begin
            tab[j] = c[31:0];
            c      = isqrt64(c << 30);
        end
        return tab;
    endfunction

endpackage

@@ design/stereo_soft_knee_compressor.sv @@
// ---------------------------------------------------------------------------
// stereo_soft_knee_compressor
// Feed-forward peak compressor with soft knee (hard knee when the knee is zero) for one stereo frame at a time.
// ---------------------------------------------------------------------------
// One frame request is taken when s_tready is high and then worked on alone;
// s_tready stays low until its result has been loaded into the output
// register. All products run through one shared 32x32 multiplier under a
// one-hot sequencer, and division through a one-bit-per-cycle restoring
// divider. A frame runs through scaling, peak and envelope, one step per
// normalization step of the envelope, the squaring steps for the fraction
// of the log and the dB conversion; a zero envelope skips the log. Gain
// reduction runs 43 divider steps and the clamp on the hard knee, with the
// soft-knee products before them inside the soft knee. The result then waits
// while the output register is still full; the next request can be taken in
// the cycle after the result is loaded. The result register frees the next
// request while the previous result waits.
// ---------------------------------------------------------------------------
module stereo_soft_knee_compressor
    import sskc_pkg::*;
#(
    parameter int unsigned LOG_TABLE_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,   // left_in[31:0], right_in[63:32]
    input  logic                  s_tlast,   // last_frame_in
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // left_out[24:0], right_out[49:25], gain_db[65:50], clipped[66],
    // frames_done[98:67], clipped_frames[130:99], max_input_peak[161:131],
    // max_output_peak[185:162], max_reduction_db[200:186], zero[207:201]
    output logic [207:0]          m_tdata,
    output logic                  m_tlast,   // last_frame_out
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned LTB  = LOG_TABLE_BITS;
    localparam int unsigned LQ_W = LTB + 7;
    localparam root_tab_t   ROOT_TAB = build_roots();

    // configuration
    logic [16:0]        headroom_reg;
    logic signed [14:0] thr_reg;
    logic [12:0]        knee_reg;
    logic [14:0]        ratio_reg;
    logic [23:0]        att_reg, rel_reg;

    state_t state_reg, state_next;
    logic [31:0] xl_mag_reg, xl_mag_next, xr_mag_reg, xr_mag_next;
    logic        l_neg_reg, l_neg_next, r_neg_reg, r_neg_next, last_reg, last_next;
    logic [31:0] sl_mag_reg, sl_mag_next, sr_mag_reg, sr_mag_next;
    logic [30:0] pk_reg, pk_next, env_reg, env_next, m_reg, m_next;
    logic [23:0] coef_reg, coef_next;
    logic [63:0] acc_reg, acc_next;
    logic [4:0]  p_reg, p_next;
    logic [LTB-1:0] frac_reg, frac_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic signed [16:0] db_reg, db_next;
    logic signed [17:0] over_reg, over_next;
    logic [14:0] x2_reg, x2_next;
    logic        hard_reg, hard_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [30:0] den_reg, den_next;
    logic [31:0] rem_reg, rem_next;
    logic [19:0] q_reg, q_next;
    logic signed [15:0] gdb_reg, gdb_next;
    logic [15:0] f_reg, f_next;
    logic [5:0]  shift_reg, shift_next;
    logic [31:0] lin_reg, lin_next;
    logic [23:0] ol_mag_reg, ol_mag_next, or_mag_reg, or_mag_next;
    logic [31:0] frames_reg, frames_next, clips_reg, clips_next;
    logic [30:0] pin_max_reg, pin_max_next;
    logic [23:0] pout_max_reg, pout_max_next;
    logic [14:0] red_max_reg, red_max_next;
    logic        m_valid_reg, m_valid_next, m_last_reg, m_last_next;
    logic [207:0] m_data_reg, m_data_next;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // helper datapath
    logic [16:0] h_sat;
    logic [31:0] pk_max;
    logic [30:0] pk_sat;
    logic [24:0] one_minus_c;
    logic [63:0] env_sum;
    logic [31:0] sq_t;
    logic signed [6:0]  p_minus;
    logic signed [LQ_W-1:0] lq;
    logic [LQ_W-1:0] lq_mag;
    logic [63:0] db_rnd;
    logic [16:0] db_mag;
    logic signed [17:0] over_w;
    logic signed [18:0] two_over, k_s;
    logic [14:0] r_eff;
    logic [31:0] div_sh;
    logic        div_ge;
    logic signed [20:0] g_w;
    logic [14:0] g_mag;
    logic [63:0] lin_rnd;
    logic [21:0] lin_u;
    logic [63:0] app_sum;
    logic [33:0] app_q;
    logic [23:0] app_mag;
    logic [24:0] ol_w, or_w;
    logic [23:0] opk;
    logic        clip;
    logic [14:0] red_w;
    logic        load_out;

    assign h_sat       = (headroom_reg > UNITY_Q16) ? UNITY_Q16 : headroom_reg;
    assign pk_max      = (sl_mag_reg > sr_mag_reg) ? sl_mag_reg : sr_mag_reg;
    assign pk_sat      = (pk_max > {1'b0, PEAK_MAX}) ? PEAK_MAX : pk_max[30:0];
    assign one_minus_c = 25'h100_0000 - {1'b0, coef_reg};
    assign env_sum     = acc_reg + mul_p;
    assign sq_t        = mul_p[61:30];
    assign p_minus     = $signed({2'b00, p_reg}) - 7'sd23;
    assign lq          = {p_minus, frac_reg};
    assign lq_mag      = lq[LQ_W-1] ? (LQ_W'(0) - lq) : lq;
    assign db_rnd      = (mul_p + (64'd1 << (LTB + 7))) >> (LTB + 8);
    assign db_mag      = db_rnd[16:0];
    assign over_w      = 18'(db_reg) - 18'(thr_reg);
    assign two_over    = {over_w, 1'b0};
    assign k_s         = {6'd0, knee_reg};
    assign r_eff       = (ratio_reg < RATIO_MIN) ? RATIO_MIN : ratio_reg;
    assign div_sh      = {rem_reg[30:0], num_reg[NUM_W-1]};
    assign div_ge      = div_sh >= {1'b0, den_reg};
    assign g_w         = hard_reg ? ($signed({1'b0, q_reg}) - 21'(over_reg))
                                  : (-$signed({1'b0, q_reg}) - 21'(over_reg));
    assign g_mag       = 15'(16'd0 - gdb_reg);
    assign lin_rnd     = (mul_p + 64'd32768) >> 16;
    assign lin_u       = 22'h20_0000 - lin_rnd[21:0];
    assign app_sum     = mul_p + (64'd1 << 29);
    assign app_q       = app_sum[63:30];
    assign app_mag     = (app_q > 34'(FULL_SCALE)) ? FULL_SCALE : app_q[23:0];
    assign ol_w        = l_neg_reg ? (25'd0 - {1'b0, ol_mag_reg}) : {1'b0, ol_mag_reg};
    assign or_w        = r_neg_reg ? (25'd0 - {1'b0, or_mag_reg}) : {1'b0, or_mag_reg};
    assign opk         = (ol_mag_reg > or_mag_reg) ? ol_mag_reg : or_mag_reg;
    assign clip        = opk >= FULL_SCALE;
    assign red_w       = g_mag;
    assign load_out    = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tlast   = m_last_reg;
    assign cfg_ready = 1'b1;

    always_comb begin
        state_next = state_reg;
        xl_mag_next = xl_mag_reg; xr_mag_next = xr_mag_reg;
        l_neg_next = l_neg_reg; r_neg_next = r_neg_reg; last_next = last_reg;
        sl_mag_next = sl_mag_reg; sr_mag_next = sr_mag_reg;
        pk_next = pk_reg; env_next = env_reg; m_next = m_reg; coef_next = coef_reg;
        acc_next = acc_reg; p_next = p_reg; frac_next = frac_reg; cnt_next = cnt_reg;
        db_next = db_reg; over_next = over_reg; x2_next = x2_reg; hard_next = hard_reg;
        num_next = num_reg; den_next = den_reg; rem_next = rem_reg; q_next = q_reg;
        gdb_next = gdb_reg; f_next = f_reg; shift_next = shift_reg; lin_next = lin_reg;
        ol_mag_next = ol_mag_reg; or_mag_next = or_mag_reg;
        frames_next = frames_reg; clips_next = clips_reg; pin_max_next = pin_max_reg;
        pout_max_next = pout_max_reg; red_max_next = red_max_reg;
        m_valid_next = m_valid_reg; m_last_next = m_last_reg; m_data_next = m_data_reg;
        mul_a = '0;
        mul_b = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    l_neg_next  = s_tdata[31];
                    r_neg_next  = s_tdata[63];
                    xl_mag_next = s_tdata[31] ? (32'd0 - s_tdata[31:0]) : s_tdata[31:0];
                    xr_mag_next = s_tdata[63] ? (32'd0 - s_tdata[63:32]) : s_tdata[63:32];
                    last_next   = s_tlast;
                    state_next  = ST_SCL;
                end
            end
            ST_SCL: begin
                mul_a = xl_mag_reg;
                mul_b = 32'(h_sat);
                sl_mag_next = mul_p[47:16];
                state_next  = ST_SCR;
            end
            ST_SCR: begin
                mul_a = xr_mag_reg;
                mul_b = 32'(h_sat);
                sr_mag_next = mul_p[47:16];
                state_next  = ST_PEAK;
            end
            ST_PEAK: begin
                pk_next    = pk_sat;
                coef_next  = (pk_sat > env_reg) ? att_reg : rel_reg;
                state_next = ST_ENV1;
            end
            ST_ENV1: begin
                mul_a = 32'(coef_reg);
                mul_b = 32'(env_reg);
                acc_next   = mul_p;
                state_next = ST_ENV2;
            end
            ST_ENV2: begin
                mul_a = 32'(one_minus_c);
                mul_b = 32'(pk_reg);
                env_next   = env_sum[54:24];
                m_next     = env_sum[54:24];
                p_next     = 5'd30;
                state_next = ST_NORM;
            end
            ST_NORM: begin
                // shift the envelope up until its top bit is set
                cnt_next  = '0;
                frac_next = '0;
                if (env_reg == '0) begin
                    db_next    = MIN_DB_Q8;
                    state_next = ST_OVER;
                end else if (m_reg[30]) begin
                    state_next = ST_SQR;
                end else if (m_reg[30:27] == 4'd0) begin
                    m_next = {m_reg[26:0], 4'd0};
                    p_next = p_reg - 5'd4;
                end else begin
                    m_next = {m_reg[29:0], 1'b0};
                    p_next = p_reg - 5'd1;
                end
            end
            ST_SQR: begin
                mul_a = 32'(m_reg);
                mul_b = 32'(m_reg);
                if (sq_t[31]) begin
                    m_next    = sq_t[31:1];
                    frac_next = {frac_reg[LTB-2:0], 1'b1};
                end else begin
                    m_next    = sq_t[30:0];
                    frac_next = {frac_reg[LTB-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(LTB - 1)) begin
                    state_next = ST_DB;
                end
            end
            ST_DB: begin
                mul_a = 32'(lq_mag);
                mul_b = DB_PER_LOG2_Q16;
                db_next    = lq[LQ_W-1] ? -$signed(db_mag) : $signed(db_mag);
                state_next = ST_OVER;
            end
            ST_OVER: begin
                over_next = over_w;
                cnt_next  = '0;
                rem_next  = '0;
                q_next    = '0;
                num_next  = NUM_W'({over_w[17:0], 8'd0});
                den_next  = 31'(r_eff);
                priority if (knee_reg == '0) begin
                    if (over_w > 18'sd0) begin
                        hard_next  = 1'b1;
                        state_next = ST_DIV;
                    end else begin
                        gdb_next   = '0;
                        state_next = ST_LIN;
                    end
                end else if (two_over <= -k_s) begin
                    gdb_next   = '0;
                    state_next = ST_LIN;
                end else if (two_over >= k_s) begin
                    hard_next  = 1'b1;
                    state_next = ST_DIV;
                end else begin
                    hard_next  = 1'b0;
                    x2_next    = 15'(two_over + k_s);
                    state_next = ST_SOFT1;
                end
            end
            ST_SOFT1: begin
                mul_a = 32'(x2_reg);
                mul_b = 32'(x2_reg);
                acc_next   = mul_p;
                state_next = ST_SOFT2;
            end
            ST_SOFT2: begin
                mul_a = 32'(acc_reg[27:0]);
                mul_b = 32'(r_eff - RATIO_MIN);
                num_next   = mul_p[NUM_W-1:0];
                state_next = ST_SOFT3;
            end
            ST_SOFT3: begin
                mul_a = 32'(knee_reg);
                mul_b = 32'(r_eff);
                den_next   = {mul_p[27:0], 3'd0};
                state_next = ST_DIV;
            end
            ST_DIV: begin
                rem_next = div_ge ? (div_sh - {1'b0, den_reg}) : div_sh;
                num_next = {num_reg[NUM_W-2:0], 1'b0};
                q_next   = {q_reg[18:0], div_ge};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(NUM_W - 1)) begin
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN: begin
                priority if (g_w > 21'sd0) begin
                    gdb_next = '0;
                end else if (g_w < 21'(MIN_DB_Q8)) begin
                    gdb_next = 16'(MIN_DB_Q8);
                end else begin
                    gdb_next = g_w[15:0];
                end
                state_next = ST_LIN;
            end
            ST_LIN: begin
                mul_a = 32'(g_mag);
                mul_b = LOG2_PER_DB_Q16;
                f_next     = lin_u[15:0];
                shift_next = 6'd32 - lin_u[21:16];
                lin_next   = 32'd1 << 30;
                cnt_next   = '0;
                state_next = ST_LINF;
            end
            ST_LINF: begin
                mul_a = lin_reg;
                mul_b = ROOT_TAB[cnt_reg[3:0]];
                if (f_reg[15]) begin
                    lin_next = mul_p[61:30];
                end
                f_next   = {f_reg[14:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(ROOT_N - 1)) begin
                    state_next = ST_LINS;
                end
            end
            ST_LINS: begin
                lin_next   = lin_reg >> shift_reg;
                state_next = ST_APPL;
            end
            ST_APPL: begin
                mul_a = sl_mag_reg;
                mul_b = lin_reg;
                ol_mag_next = app_mag;
                state_next  = ST_APPR;
            end
            ST_APPR: begin
                mul_a = sr_mag_reg;
                mul_b = lin_reg;
                or_mag_next = app_mag;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (load_out) begin
                    frames_next   = (frames_reg == '1) ? frames_reg : frames_reg + 32'd1;
                    clips_next    = (clip && clips_reg != '1) ? clips_reg + 32'd1 : clips_reg;
                    pin_max_next  = (pk_reg > pin_max_reg) ? pk_reg : pin_max_reg;
                    pout_max_next = (opk > pout_max_reg) ? opk : pout_max_reg;
                    red_max_next  = (red_w > red_max_reg) ? red_w : red_max_reg;
                    m_data_next   = {7'd0, red_max_next, pout_max_next, pin_max_next,
                                     clips_next, frames_next, clip, gdb_reg, or_w, ol_w};
                    m_last_next   = last_reg;
                    m_valid_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            headroom_reg <= HEADROOM_RST;
            thr_reg      <= THRESHOLD_RST;
            knee_reg     <= KNEE_RST;
            ratio_reg    <= RATIO_RST;
            att_reg      <= ATTACK_RST;
            rel_reg      <= RELEASE_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_HEADROOM:  headroom_reg <= cfg_data[16:0];
                REG_THRESHOLD: thr_reg      <= cfg_data[14:0];
                REG_KNEE:      knee_reg     <= cfg_data[12:0];
                REG_RATIO:     ratio_reg    <= cfg_data[14:0];
                REG_ATTACK:    att_reg      <= cfg_data[23:0];
                REG_RELEASE:   rel_reg      <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            env_reg      <= '0;
            frames_reg   <= '0;
            clips_reg    <= '0;
            pin_max_reg  <= '0;
            pout_max_reg <= '0;
            red_max_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            env_reg      <= env_next;
            frames_reg   <= frames_next;
            clips_reg    <= clips_next;
            pin_max_reg  <= pin_max_next;
            pout_max_reg <= pout_max_next;
            red_max_reg  <= red_max_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        xl_mag_reg <= xl_mag_next; xr_mag_reg <= xr_mag_next;
        l_neg_reg  <= l_neg_next;  r_neg_reg  <= r_neg_next;  last_reg <= last_next;
        sl_mag_reg <= sl_mag_next; sr_mag_reg <= sr_mag_next;
        pk_reg     <= pk_next;     m_reg      <= m_next;      coef_reg <= coef_next;
        acc_reg    <= acc_next;    p_reg      <= p_next;      frac_reg <= frac_next;
        cnt_reg    <= cnt_next;    db_reg     <= db_next;     over_reg <= over_next;
        x2_reg     <= x2_next;     hard_reg   <= hard_next;
        num_reg    <= num_next;    den_reg    <= den_next;
        rem_reg    <= rem_next;    q_reg      <= q_next;
        gdb_reg    <= gdb_next;    f_reg      <= f_next;
        shift_reg  <= shift_next;  lin_reg    <= lin_next;
        ol_mag_reg <= ol_mag_next; or_mag_reg <= or_mag_next;
        m_last_reg <= m_last_next; m_data_reg <= m_data_next;
    end

    // s_tready is low in the cycle after a request is accepted
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted but block still ready");

    // restoring divider keeps its partial remainder below the divisor
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < {1'b0, den_reg}))
        else $error("divider remainder out of range");

    // the mantissa stays normalized through the squaring steps
    a_sqr_norm: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQR) |-> m_reg[30])
        else $error("log mantissa lost normalization");

    // gain stays within its clamp once it is computed
    a_gain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LIN) |-> (gdb_reg <= 16'sd0 && gdb_reg >= 16'(MIN_DB_Q8)))
        else $error("gain out of range");

endmodule
